@@ sv/lbbr_pkg.sv @@
package lbbr_pkg;

   // request operations
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_PROBE  = 1'b1;

   // event kinds
   localparam logic [1:0] EVT_TOUCH  = 2'd0;
   localparam logic [1:0] EVT_EVICT  = 2'd1;
   localparam logic [1:0] EVT_INSERT = 2'd2;
   localparam logic [1:0] EVT_PROBE  = 2'd3;

   // register file: one 64-bit register per 8-byte slot
   localparam int          ADDR_W       = 4;
   localparam logic        REG_CAPACITY = 1'b0;
   localparam int          CAP_W        = 48;
   localparam int          DATA_W       = 64;

   localparam int          BYTES_OUT_W  = 38;
   localparam int          PAGES_OUT_W  = 7;

   typedef struct packed {
      logic [1:0]             kind;
      logic [31:0]            page;
      logic                   hit;
      logic                   last;
      logic [BYTES_OUT_W-1:0] bytes;
      logic [PAGES_OUT_W-1:0] pages;
      logic [31:0]            ins;
      logic [31:0]            evi;
      logic [31:0]            tch;
   } evt_type;

endpackage

@@ sv/lbbr_ram.sv @@
module lbbr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/lbbr_csr.sv @@
module lbbr_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lbbr_pkg::ADDR_W-1:0]  paddr,
   input  logic [lbbr_pkg::DATA_W-1:0]  pwdata,
   output logic [lbbr_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output logic [lbbr_pkg::CAP_W-1:0]   capacity
);

   logic [lbbr_pkg::CAP_W-1:0] cap_ff;
   logic [lbbr_pkg::CAP_W-1:0] cap_in;
   logic                       sel_cap;

   // low three address bits are ignored; bit 3 selects the 64-bit register
   assign sel_cap = (paddr[lbbr_pkg::ADDR_W-1:3] == lbbr_pkg::REG_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && sel_cap) begin
         cap_in = pwdata[lbbr_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign prdata   = sel_cap ? lbbr_pkg::DATA_W'(cap_ff) : '0;
   assign pready   = 1'b1;
   assign capacity = cap_ff;

endmodule

@@ sv/lbbr_ctrl.sv @@
module lbbr_ctrl #(
   parameter int MAX_PAGES = 64,
   parameter int MAX_EVICT = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lbbr_pkg::CAP_W-1:0] capacity,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic [31:0]                req_page_id,
   input  logic [31:0]                req_page_size,
   input  logic                       out_free,
   output logic                       evt_valid,
   output lbbr_pkg::evt_type          evt
);

   localparam int AW = $clog2(MAX_PAGES);
   localparam int CW = $clog2(MAX_PAGES + 1);
   localparam int BW = 32 + AW;
   localparam int EW = $clog2(MAX_EVICT + 1);
   localparam int SW = lbbr_pkg::CAP_W + 1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SCAN  = 8'b0000_0010,
      ST_EVAL  = 8'b0000_0100,
      ST_VREAD = 8'b0000_1000,
      ST_VEMIT = 8'b0001_0000,
      ST_SHIFT = 8'b0010_0000,
      ST_PUT   = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic           op_ff, op_in;
   logic [31:0]    id_ff, id_in;
   logic [31:0]    size_ff, size_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  rdidx_ff, rdidx_in;
   logic [AW-1:0]  wdst_ff, wdst_in;
   logic           hit_ff, hit_in;
   logic [EW-1:0]  nev_ff, nev_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [BW-1:0]  bytes_ff, bytes_in;
   logic [31:0]    ins_ff, ins_in;
   logic [31:0]    evi_ff, evi_in;
   logic [31:0]    tch_ff, tch_in;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [63:0]    ram_wdata;
   logic           ram_re;
   logic [AW-1:0]  ram_raddr;
   logic [63:0]    ram_rdata;
   logic [31:0]    rd_page;
   logic [31:0]    rd_size;

   logic [CW-1:0]  cnt_m1;
   logic [CW-1:0]  ptr_m1;
   logic [SW-1:0]  need_sum;
   logic           need_room;
   logic [1:0]     ev_kind;
   logic [31:0]    ev_page;
   logic           ev_last;
   logic [63:0]    bytes_wide;
   logic [31:0]    cnt_wide;

   // entries held in recency order: address 0 is the most recent page
   lbbr_ram #(
      .WIDTH(64),
      .DEPTH(MAX_PAGES)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rd_page   = ram_rdata[63:32];
   assign rd_size   = ram_rdata[31:0];
   assign cnt_m1    = cnt_ff - CW'(1);
   assign ptr_m1    = ptr_ff - CW'(1);
   assign need_sum  = SW'(bytes_ff) + SW'(size_ff);
   assign need_room = (need_sum > SW'(capacity)) || (cnt_ff >= CW'(MAX_PAGES));
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      id_in     = id_ff;
      size_in   = size_ff;
      ptr_in    = ptr_ff;
      pend_in   = pend_ff;
      rdidx_in  = rdidx_ff;
      wdst_in   = wdst_ff;
      hit_in    = hit_ff;
      nev_in    = nev_ff;
      cnt_in    = cnt_ff;
      bytes_in  = bytes_ff;
      ins_in    = ins_ff;
      evi_in    = evi_ff;
      tch_in    = tch_ff;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = {id_ff, size_ff};
      ram_re    = 1'b0;
      ram_raddr = '0;
      evt_valid = 1'b0;
      ev_kind   = lbbr_pkg::EVT_PROBE;
      ev_page   = id_ff;
      ev_last   = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               id_in    = req_page_id;
               size_in  = req_page_size;
               ptr_in   = '0;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               nev_in   = '0;
               state_in = ST_SCAN;
            end
         end

         // one read issued per cycle, compared against the page id once its registered read data returns
         ST_SCAN: begin
            if (pend_ff && (rd_page == id_ff)) begin
               hit_in  = 1'b1;
               pend_in = 1'b0;
               ptr_in  = CW'(rdidx_ff);
               if (op_ff == lbbr_pkg::OP_PROBE) begin
                  state_in = ST_FIN;
               end else begin
                  size_in  = rd_size;
                  state_in = ST_SHIFT;
               end
            end else if (ptr_ff >= cnt_ff) begin
               hit_in  = 1'b0;
               pend_in = 1'b0;
               if (op_ff == lbbr_pkg::OP_PROBE) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_EVAL;
               end
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ptr_ff[AW-1:0];
               pend_in   = 1'b1;
               rdidx_in  = ptr_ff[AW-1:0];
               ptr_in    = ptr_ff + CW'(1);
            end
         end

         ST_EVAL: begin
            if (need_room && (cnt_ff != '0) && (nev_ff < EW'(MAX_EVICT))) begin
               state_in = ST_VREAD;
            end else begin
               ptr_in   = cnt_ff;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end
         end

         // oldest page sits at the end of the list
         ST_VREAD: begin
            ram_re    = 1'b1;
            ram_raddr = cnt_m1[AW-1:0];
            state_in  = ST_VEMIT;
         end

         ST_VEMIT: begin
            if (out_free) begin
               bytes_in  = bytes_ff - BW'(rd_size);
               cnt_in    = cnt_m1;
               evi_in    = evi_ff + 32'd1;
               nev_in    = nev_ff + EW'(1);
               evt_valid = 1'b1;
               ev_kind   = lbbr_pkg::EVT_EVICT;
               ev_page   = rd_page;
               ev_last   = 1'b0;
               state_in  = ST_EVAL;
            end
         end

         // move entries 0..ptr-1 up by one, top first
         ST_SHIFT: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wdst_ff;
               ram_wdata = ram_rdata;
            end
            if (ptr_ff != '0) begin
               ram_re    = 1'b1;
               ram_raddr = ptr_m1[AW-1:0];
               wdst_in   = ptr_ff[AW-1:0];
               pend_in   = 1'b1;
               ptr_in    = ptr_m1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_PUT;
            end
         end

         ST_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            if (hit_ff) begin
               tch_in = tch_ff + 32'd1;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               bytes_in = bytes_ff + BW'(size_ff);
               ins_in   = ins_ff + 32'd1;
            end
            state_in = ST_FIN;
         end

         ST_FIN: begin
            if (out_free) begin
               evt_valid = 1'b1;
               if (op_ff == lbbr_pkg::OP_PROBE) begin
                  ev_kind = lbbr_pkg::EVT_PROBE;
               end else if (hit_ff) begin
                  ev_kind = lbbr_pkg::EVT_TOUCH;
               end else begin
                  ev_kind = lbbr_pkg::EVT_INSERT;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign bytes_wide = 64'(bytes_in);
   assign cnt_wide   = 32'(cnt_in);

   always_comb begin
      evt.kind  = ev_kind;
      evt.page  = ev_page;
      evt.hit   = hit_ff && (ev_kind != lbbr_pkg::EVT_EVICT);
      evt.last  = ev_last;
      evt.bytes = bytes_wide[lbbr_pkg::BYTES_OUT_W-1:0];
      evt.pages = cnt_wide[lbbr_pkg::PAGES_OUT_W-1:0];
      evt.ins   = ins_in;
      evt.evi   = evi_in;
      evt.tch   = tch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         nev_ff   <= '0;
         cnt_ff   <= '0;
         bytes_ff <= '0;
         ins_ff   <= '0;
         evi_ff   <= '0;
         tch_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         nev_ff   <= nev_in;
         cnt_ff   <= cnt_in;
         bytes_ff <= bytes_in;
         ins_ff   <= ins_in;
         evi_ff   <= evi_in;
         tch_ff   <= tch_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      id_ff    <= id_in;
      size_ff  <= size_in;
      ptr_ff   <= ptr_in;
      rdidx_ff <= rdidx_in;
      wdst_ff  <= wdst_in;
      hit_ff   <= hit_in;
   end

endmodule

@@ sv/lru_byte_budget_residency.sv @@
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | operation, page_id, page_size
// rsp     | out       | rsp_valid/rsp_stall | event fields and running totals
// csr     | in        | psel/penable/pready | capacity_bytes at byte address 0
//
// Scan: one entry a cycle, ending at a hit or after the last resident page. Probe: scan,
// then report. Touch: scan, shift newer entries, write head, report. Insert: scan, read
// and report each victim (at most MAX_EVICT), shift remaining pages, write head, report.
// The list memory has one read and one write port, both busy while shifting.
// Reset is synchronous and empties the list; capacity resets to zero. A stalled result
// holds the sequencer; the next request is taken once the last result is registered.
module lru_byte_budget_residency #(
   parameter int MAX_PAGES = 64,
   parameter int MAX_EVICT = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic [31:0]                           req_page_id,
   input  logic [31:0]                           req_page_size,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_event_kind,
   output logic [31:0]                           rsp_event_page,
   output logic                                  rsp_is_resident,
   output logic                                  rsp_last,
   output logic [lbbr_pkg::BYTES_OUT_W-1:0]      rsp_resident_bytes,
   output logic [lbbr_pkg::PAGES_OUT_W-1:0]      rsp_resident_pages,
   output logic [31:0]                           rsp_insert_count,
   output logic [31:0]                           rsp_evict_count,
   output logic [31:0]                           rsp_touch_count,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lbbr_pkg::ADDR_W-1:0]           paddr,
   input  logic [lbbr_pkg::DATA_W-1:0]           pwdata,
   output logic [lbbr_pkg::DATA_W-1:0]           prdata,
   output logic                                  pready
);

   logic [lbbr_pkg::CAP_W-1:0] capacity;
   logic                       out_free;
   logic                       evt_valid;
   lbbr_pkg::evt_type          evt;
   lbbr_pkg::evt_type          rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   lbbr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .capacity(capacity)
   );

   lbbr_ctrl #(
      .MAX_PAGES(MAX_PAGES),
      .MAX_EVICT(MAX_EVICT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .capacity     (capacity),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_operation(req_operation),
      .req_page_id  (req_page_id),
      .req_page_size(req_page_size),
      .out_free     (out_free),
      .evt_valid    (evt_valid),
      .evt          (evt)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (evt_valid) begin
         rsp_in       = evt;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_ff.kind;
   assign rsp_event_page     = rsp_ff.page;
   assign rsp_is_resident    = rsp_ff.hit;
   assign rsp_last           = rsp_ff.last;
   assign rsp_resident_bytes = rsp_ff.bytes;
   assign rsp_resident_pages = rsp_ff.pages;
   assign rsp_insert_count   = rsp_ff.ins;
   assign rsp_evict_count    = rsp_ff.evi;
   assign rsp_touch_count    = rsp_ff.tch;

endmodule
